FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the helix length accumulator RTL.
// Depends on nothing; users must provide clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a concurrent property on every rising clock edge outside reset
`define HLA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that an antecedent is followed in the next cycle by a consequent
`define HLA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/hla_pkg.sv
// Package for the helix length accumulator: widths, angle constants, mode codes.
// No dependencies.
package hla_pkg;

	localparam int LEN_W  = 48;
	localparam int WORK_W = 2 * LEN_W;
	localparam int CNT_W  = $clog2(LEN_W);

	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	// pi and 2*pi with 13 fraction bits
	localparam logic [16:0] PHI_PI     = 17'd25736;
	localparam logic [16:0] PHI_TWO_PI = 17'd51472;

	typedef enum logic [1:0] {
		MODE_PHI   = 2'd0,
		MODE_Z     = 2'd1,
		MODE_CHORD = 2'd2,
		MODE_SPARE = 2'd3
	} mode_t;

endpackage

FILE: hw/rtl/hla_ifs.sv
// Channel interfaces for the helix length accumulator: item, result, mode write.
// Depends on hla_pkg.
interface hla_item_if;
	logic        valid;
	logic        ready;
	logic [15:0] phi;
	logic [31:0] omega;
	logic [31:0] tan_lambda;
	logic [31:0] ref_z;
	logic [31:0] z_offset;
	logic        last;
	modport source (output valid, phi, omega, tan_lambda, ref_z, z_offset, last, input ready);
	modport sink   (input valid, phi, omega, tan_lambda, ref_z, z_offset, last, output ready);
endinterface

interface hla_result_if;
	logic                    valid;
	logic                    ready;
	logic [hla_pkg::LEN_W-1:0] track_length;
	logic                    overflow;
	modport source (output valid, track_length, overflow, input ready);
	modport sink   (input valid, track_length, overflow, output ready);
endinterface

interface hla_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

FILE: hw/rtl/helix_length_accumulator_core.sv
// Helix length accumulator top level: bit-serial multiply, divide and square root.
// Depends on hla_pkg, hla_ifs.sv and assert_macros.svh.
//
// Usage:
//  item_in    : one helix track state per transaction (phi, omega, tan_lambda,
//               ref_z, z_offset, last). Ready is high only while the core idles.
//  result_out : one transaction per track, on the item marked last, carrying the
//               saturating track_length and the overflow flag.
//  cfg        : writes the two-bit mode register; always ready.
// Sequence: the first item of a track runs no pass. Later items run a shared
//  one-bit-per-cycle unit through four passes of 48 steps each (mode 0 and 1:
//  t*t, sqrt, product, divide; modes 2 and 3: divide, a*a, dz*dz, sqrt). In
//  modes 0 and 1 a quotient too wide for the sum skips the divide and
//  saturates. A zero divisor skips the passes and saturates.
// Reset clears the mode to 0 and the track state. A stalled result holds in the
//  output register; a following last item waits until that register is free.
module helix_length_accumulator_core (
	input  logic          clk,
	input  logic          arst_n,
	hla_item_if.sink      item_in,
	hla_result_if.source  result_out,
	hla_cfg_if.sink       cfg
);
	import hla_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_MSQ, S_SEC, S_MNUM, S_DIV, S_MA, S_MZ, S_ROOT, S_ACC, S_FIN
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [1:0]        mode_q;
	logic [1:0]        mode_act_q;
	logic [15:0]       prev_phi_q;
	logic [31:0]       prev_omega_q;
	logic [31:0]       prev_tl_q;
	logic [32:0]       prev_z_q;
	logic              have_prev_q;
	logic [LEN_W-1:0]  sum_q;
	logic              sat_q;
	logic              last_q;
	logic              bad_q;
	logic [14:0]       dphi_q;
	logic [33:0]       dz_q;
	logic [31:0]       dsr_q;
	logic [LEN_W-1:0]  op_a_q;
	logic [WORK_W-1:0] work_q;
	logic [WORK_W-1:0] sq_q;
	logic [50:0]       rem_q;
	logic [LEN_W-1:0]  root_q;
	logic [LEN_W-1:0]  seg_q;
	logic              out_valid_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              out_ovf_q;

	logic              accept;
	logic              cnt_last;
	logic [16:0]       phi_diff, phi_abs, phi_w1, phi_w2;
	logic [32:0]       z_new;
	logic [33:0]       z_diff, dz_abs;
	logic [31:0]       aom, at;
	logic [LEN_W:0]    mul_sum;
	logic [WORK_W-1:0] mul_next;
	logic [32:0]       div_rem, div_rem_next;
	logic              div_ge;
	logic [WORK_W-1:0] div_work_next;
	logic [50:0]       sq_rem, sq_trial, sq_rem_next;
	logic              sq_ge;
	logic [LEN_W-1:0]  root_next;
	logic [LEN_W:0]    acc_sum;
	logic              out_free;

	assign accept   = item_in.valid && item_in.ready;
	assign cnt_last = (cnt_q == CNT_W'(LEN_W - 1));
	assign out_free = !out_valid_q || result_out.ready;

	assign item_in.ready        = (state_q == S_IDLE);
	assign cfg.ready            = 1'b1;
	assign result_out.valid     = out_valid_q;
	assign result_out.track_length = out_len_q;
	assign result_out.overflow  = out_ovf_q;

	// Wrapped phi and z differences of a new item, divisor magnitudes of the stored item
	always_comb begin
		phi_diff = {item_in.phi[15], item_in.phi} - {prev_phi_q[15], prev_phi_q};
		phi_abs  = phi_diff[16] ? 17'(-phi_diff) : phi_diff;
		phi_w1   = (phi_abs > PHI_TWO_PI) ? phi_abs - PHI_TWO_PI : phi_abs;
		phi_w2   = (phi_w1 > PHI_PI) ? PHI_TWO_PI - phi_w1 : phi_w1;
		z_new    = {item_in.ref_z[31], item_in.ref_z} + {item_in.z_offset[31], item_in.z_offset};
		z_diff   = {z_new[32], z_new} - {prev_z_q[32], prev_z_q};
		dz_abs   = z_diff[33] ? 34'(-z_diff) : z_diff;
		aom      = prev_omega_q[31] ? 32'(-prev_omega_q) : prev_omega_q;
		at       = prev_tl_q[31] ? 32'(-prev_tl_q) : prev_tl_q;
	end

	// Shift-add multiply step: add multiplicand on the low bit, shift right
	always_comb begin
		mul_sum  = {1'b0, work_q[WORK_W-1:LEN_W]} + (work_q[0] ? {1'b0, op_a_q} : '0);
		mul_next = {mul_sum, work_q[LEN_W-1:1]};
	end

	// Restoring divide step: one quotient bit enters at the bottom
	always_comb begin
		div_rem       = {rem_q[31:0], work_q[WORK_W-1]};
		div_ge        = div_rem >= {1'b0, dsr_q};
		div_rem_next  = div_ge ? div_rem - {1'b0, dsr_q} : div_rem;
		div_work_next = {work_q[WORK_W-2:0], div_ge};
	end

	// Square root step: two radicand bits in, one root bit out
	always_comb begin
		sq_rem      = {rem_q[48:0], work_q[WORK_W-1:WORK_W-2]};
		sq_trial    = {1'b0, root_q, 2'b01};
		sq_ge       = sq_rem >= sq_trial;
		sq_rem_next = sq_ge ? sq_rem - sq_trial : sq_rem;
		root_next   = {root_q[LEN_W-2:0], sq_ge};
	end

	assign acc_sum = {1'b0, sum_q} + {1'b0, seg_q};

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PHI;
		end else if (cfg.valid && cfg.ready) begin
			mode_q <= cfg.data;
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && last_q && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && last_q && out_free) begin
			out_len_q <= sum_q;
			out_ovf_q <= sat_q;
		end
	end

	// Sequencer and track state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			have_prev_q  <= 1'b0;
			sum_q        <= '0;
			sat_q        <= 1'b0;
			prev_phi_q   <= '0;
			prev_omega_q <= '0;
			prev_tl_q    <= '0;
			prev_z_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q        <= '0;
						prev_phi_q   <= item_in.phi;
						prev_omega_q <= item_in.omega;
						prev_tl_q    <= item_in.tan_lambda;
						prev_z_q     <= z_new;
						have_prev_q  <= 1'b1;
						if (!have_prev_q) begin
							state_q <= S_FIN;
						end else if (mode_q == MODE_PHI || mode_q == MODE_Z) begin
							if ((mode_q == MODE_PHI ? aom : at) == '0) begin
								state_q <= S_ACC;
							end else begin
								state_q <= S_MSQ;
							end
						end else begin
							if (aom == '0) begin
								state_q <= S_ACC;
							end else begin
								state_q <= S_DIV;
							end
						end
					end
				end
				S_MSQ, S_SEC, S_MNUM, S_DIV, S_MA, S_MZ, S_ROOT: begin
					if (cnt_last) begin
						cnt_q <= '0;
						case (state_q)
							S_MSQ:  state_q <= S_SEC;
							S_SEC:  state_q <= S_MNUM;
							S_MNUM: state_q <= (mul_next[WORK_W-1:LEN_W] >= {16'd0, dsr_q})
								? S_ACC : S_DIV;
							S_DIV:  state_q <= (mode_act_q == MODE_PHI || mode_act_q == MODE_Z)
								? S_ACC : S_MA;
							S_MA:   state_q <= S_MZ;
							S_MZ:   state_q <= S_ROOT;
							default: state_q <= S_ACC;
						endcase
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_ACC: begin
					if (bad_q || acc_sum[LEN_W]) begin
						sum_q <= LEN_MAX;
						sat_q <= 1'b1;
					end else begin
						sum_q <= acc_sum[LEN_W-1:0];
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						have_prev_q <= 1'b0;
						sum_q       <= '0;
						sat_q       <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Serial datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					mode_act_q <= mode_q;
					last_q     <= item_in.last;
					dphi_q     <= phi_w2[14:0];
					dz_q       <= dz_abs;
					rem_q      <= '0;
					seg_q      <= '0;
					if (mode_q == MODE_PHI || mode_q == MODE_Z) begin
						bad_q  <= have_prev_q && ((mode_q == MODE_PHI ? aom : at) == '0);
						dsr_q  <= (mode_q == MODE_PHI) ? aom : at;
						op_a_q <= LEN_W'(at);
						work_q <= WORK_W'(at);
					end else begin
						bad_q  <= have_prev_q && (aom == '0);
						dsr_q  <= aom;
						// numerator dphi * 2^29 sits in the upper half, lower half is zero
						work_q <= {LEN_W'({phi_w2[14:0], 29'd0}), {LEN_W{1'b0}}};
					end
				end
			end
			S_MSQ: begin
				if (cnt_last) begin
					// radicand t^2 + 2^32
					work_q <= mul_next + (WORK_W'(1) << 32);
					rem_q  <= '0;
					root_q <= '0;
				end else begin
					work_q <= mul_next;
				end
			end
			S_SEC, S_ROOT: begin
				rem_q  <= sq_rem_next;
				root_q <= root_next;
				if (cnt_last) begin
					op_a_q <= root_next;
					seg_q  <= root_next;
					work_q <= (mode_act_q == MODE_PHI)
						? WORK_W'({dphi_q, 13'd0}) : WORK_W'(dz_q);
				end else begin
					work_q <= {work_q[WORK_W-3:0], 2'b00};
				end
			end
			S_MNUM: begin
				if (cnt_last) begin
					bad_q  <= mul_next[WORK_W-1:LEN_W] >= {16'd0, dsr_q};
					rem_q  <= 51'(mul_next[WORK_W-1:LEN_W]);
					work_q <= {mul_next[LEN_W-1:0], {LEN_W{1'b0}}};
				end else begin
					work_q <= mul_next;
				end
			end
			S_DIV: begin
				rem_q  <= 51'(div_rem_next);
				if (cnt_last) begin
					seg_q  <= div_work_next[LEN_W-1:0];
					op_a_q <= div_work_next[LEN_W-1:0];
					work_q <= WORK_W'(div_work_next[LEN_W-1:0]);
				end else begin
					work_q <= div_work_next;
				end
			end
			S_MA: begin
				if (cnt_last) begin
					sq_q   <= mul_next;
					op_a_q <= LEN_W'(dz_q);
					work_q <= WORK_W'(dz_q);
				end else begin
					work_q <= mul_next;
				end
			end
			S_MZ: begin
				if (cnt_last) begin
					work_q <= mul_next + sq_q;
					rem_q  <= '0;
					root_q <= '0;
				end else begin
					work_q <= mul_next;
				end
			end
			default: begin
			end
		endcase
	end

	`include "assert_macros.svh"

	`HLA_ASSERT(a_sat_holds_max, !sat_q || sum_q == LEN_MAX, "saturated sum is not at maximum")
	`HLA_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != S_IDLE, "accepted item left core idle")
	`HLA_ASSERT(a_result_from_last, !$rose(out_valid_q) || $past(last_q), "result raised without last")
	`HLA_ASSERT_NEXT(a_acc_then_fin, state_q == S_ACC, state_q == S_FIN, "accumulate not followed by finish")

endmodule
